@@ design/dosc_pkg.sv @@
// Types, constants and operation decode shared by the damped oscillator step core.
`timescale 1ns / 1ps

package dosc_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_STIFFNESS    = 3'd0;
  localparam logic [2:0] CFG_DAMPING      = 3'd1;
  localparam logic [2:0] CFG_MASS         = 3'd2;
  localparam logic [2:0] CFG_INVERSE_MASS = 3'd3;
  localparam logic [2:0] CFG_TIME_STEP    = 3'd4;

  localparam logic [31:0] STIFFNESS_RST    = 32'd655360;
  localparam logic [31:0] DAMPING_RST      = 32'd0;
  localparam logic [31:0] MASS_RST         = 32'd65536;
  localparam logic [31:0] INVERSE_MASS_RST = 32'd65536;
  localparam logic [31:0] TIME_STEP_RST    = 32'd429497;

  localparam logic signed [47:0] VEL_RST   = 48'sh000F_0000_0000;
  localparam logic [31:0]        TENTH_Q32 = 32'd429496730;

  localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;
  localparam logic [47:0]        U48_MAX = 48'hFFFF_FFFF_FFFF;

  // Multiplier bit counts
  localparam logic [5:0] MUL_SHORT = 6'd32;
  localparam logic [5:0] MUL_LONG  = 6'd48;

  typedef enum logic [0:0] {
    CMD_TICK    = 1'b0,
    CMD_IMPULSE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_FIN,
    ST_POST,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_FS,   // k * x
    OP_FD,   // b * v, then force = -(fs + fd)
    OP_A,    // force * inverse_mass
    OP_DV,   // a * dt into velocity
    OP_DX,   // v * dt into position
    OP_IP,   // impulse force * 0.1
    OP_IV,   // impulse term * inverse_mass into velocity
    OP_KE1,  // |v| * m
    OP_KE2,  // (|v| * m) * |v| / 2
    OP_PE1,  // |x| * k
    OP_PE2   // (|x| * k) * |x| / 2
  } op_e;

  typedef enum logic [1:0] {
    SH_16,
    SH_32,
    SH_33
  } shift_e;

  typedef enum logic [1:0] {
    CAP_S48,   // signed Q16.32 range, sign applied afterwards
    CAP_NONE,  // 64-bit intermediate, cannot overflow
    CAP_U48    // unsigned energy range
  } cap_e;

  typedef struct packed {
    shift_e sh;
    cap_e   cap;
    logic   long_mul;
  } op_ctl_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] force_req;
  } dosc_in_t;

  typedef struct packed {
    logic signed [47:0] position;
    logic [47:0]        energy_kin;
    logic [47:0]        energy_pot;
    logic [47:0]        energy_sum;
  } dosc_out_t;

  function automatic op_ctl_t op_ctl(input op_e op);
    op_ctl_t c;
    c.sh       = SH_16;
    c.cap      = CAP_S48;
    c.long_mul = 1'b0;
    case (op)
      OP_DV, OP_DX, OP_IP: c.sh = SH_32;
      OP_KE1, OP_PE1:      c.cap = CAP_NONE;
      OP_KE2, OP_PE2: begin
        c.sh       = SH_33;
        c.cap      = CAP_U48;
        c.long_mul = 1'b1;
      end
      default: c.sh = SH_16;
    endcase
    return c;
  endfunction

  function automatic op_e next_op(input op_e op);
    op_e n;
    case (op)
      OP_FS:   n = OP_FD;
      OP_FD:   n = OP_A;
      OP_A:    n = OP_DV;
      OP_DV:   n = OP_DX;
      OP_DX:   n = OP_KE1;
      OP_IP:   n = OP_IV;
      OP_IV:   n = OP_KE1;
      OP_KE1:  n = OP_KE2;
      OP_KE2:  n = OP_PE1;
      OP_PE1:  n = OP_PE2;
      default: n = OP_FS;
    endcase
    return n;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > 50'(S48_MAX)) begin
      r = S48_MAX;
    end else if (v < 50'(S48_MIN)) begin
      r = S48_MIN;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

@@ design/damped_oscillator_euler_step_core.sv @@
// Damped mass-spring state with a bit-serial multiplier running one Euler step per item.
// Each multiplication, with a 32-bit or a 48-bit operand, runs bit by bit on the single
// shared shift-add multiplier. An item is taken only in the idle state, so a new item is
// not accepted until the last result has been handed to the output register.
// Reset: position 0, velocity 15.0, registers at their defaults; no clearing pass.
`timescale 1ns / 1ps

module damped_oscillator_euler_step_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dosc_pkg::dosc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dosc_pkg::dosc_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  dosc_pkg::state_e state_q, state_d;
  dosc_pkg::op_e    op_q, op_d;
  dosc_pkg::op_ctl_t ctl;

  logic [31:0] stiff_q, damp_q, mass_q, invm_q, dt_q;
  logic signed [47:0] x_q, v_q;
  logic               cmd_q;
  logic signed [31:0] force_q;
  logic signed [47:0] f_q;
  logic [63:0]        t_q;
  logic [47:0]        ke_q, pe_q;

  // multiplier
  logic [63:0] a_q, acc_q;
  logic [47:0] mlo_q;
  logic [5:0]  cnt_q;
  logic        long_q, neg_q;
  logic [63:0] res_q;

  logic                out_valid_q;
  dosc_pkg::dosc_out_t out_q;

  logic in_fire, out_free;
  logic load_en, run_en, fin_en, post_en, done_en;

  logic signed [47:0] src;
  logic [47:0]        mag;
  logic [63:0]        mul_a;
  logic [47:0]        mul_b;
  logic [64:0]        sum;
  logic [111:0]       prod, shifted;
  logic               over_s, over_u;
  logic [47:0]        r48;
  logic signed [47:0] res48;
  logic signed [49:0] fsum, vsum, xsum;
  logic [48:0]        tot;

  assign ctl      = dosc_pkg::op_ctl(op_q);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      dosc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = dosc_pkg::ST_LOAD;
          op_d    = (in_data_i.cmd == dosc_pkg::CMD_IMPULSE) ? dosc_pkg::OP_IP
                                                              : dosc_pkg::OP_FS;
        end
      end
      dosc_pkg::ST_LOAD: state_d = dosc_pkg::ST_RUN;
      dosc_pkg::ST_RUN: begin
        if (cnt_q == 6'd1) state_d = dosc_pkg::ST_FIN;
      end
      dosc_pkg::ST_FIN: state_d = dosc_pkg::ST_POST;
      dosc_pkg::ST_POST: begin
        if (op_q == dosc_pkg::OP_PE2) begin
          state_d = dosc_pkg::ST_DONE;
        end else begin
          state_d = dosc_pkg::ST_LOAD;
          op_d    = dosc_pkg::next_op(op_q);
        end
      end
      dosc_pkg::ST_DONE: begin
        if (out_free) state_d = dosc_pkg::ST_IDLE;
      end
      default: state_d = dosc_pkg::ST_IDLE;
    endcase
  end

  // Outputs and strobes
  always_comb begin
    in_ready_o = 1'b0;
    load_en    = 1'b0;
    run_en     = 1'b0;
    fin_en     = 1'b0;
    post_en    = 1'b0;
    done_en    = 1'b0;
    case (state_q)
      dosc_pkg::ST_IDLE: in_ready_o = 1'b1;
      dosc_pkg::ST_LOAD: load_en    = 1'b1;
      dosc_pkg::ST_RUN:  run_en     = 1'b1;
      dosc_pkg::ST_FIN:  fin_en     = 1'b1;
      dosc_pkg::ST_POST: post_en    = 1'b1;
      dosc_pkg::ST_DONE: done_en    = out_free;
      default:           in_ready_o = 1'b0;
    endcase
  end

  // Operand selection
  always_comb begin
    case (op_q)
      dosc_pkg::OP_FS, dosc_pkg::OP_PE1, dosc_pkg::OP_PE2: src = x_q;
      dosc_pkg::OP_FD, dosc_pkg::OP_DX, dosc_pkg::OP_KE1,
      dosc_pkg::OP_KE2:                                    src = v_q;
      dosc_pkg::OP_IP:                                     src = {force_q, 16'd0};
      default:                                             src = f_q;
    endcase
  end

  assign mag = src[47] ? (48'd0 - src) : src;

  always_comb begin
    mul_a = {16'd0, mag};
    case (op_q)
      dosc_pkg::OP_FS, dosc_pkg::OP_PE1: mul_b = {16'd0, stiff_q};
      dosc_pkg::OP_FD:                   mul_b = {16'd0, damp_q};
      dosc_pkg::OP_A, dosc_pkg::OP_IV:   mul_b = {16'd0, invm_q};
      dosc_pkg::OP_DV, dosc_pkg::OP_DX:  mul_b = {16'd0, dt_q};
      dosc_pkg::OP_IP:                   mul_b = {16'd0, dosc_pkg::TENTH_Q32};
      dosc_pkg::OP_KE1:                  mul_b = {16'd0, mass_q};
      dosc_pkg::OP_KE2, dosc_pkg::OP_PE2: begin
        mul_a = t_q;
        mul_b = mag;
      end
      default:                           mul_b = 48'd0;
    endcase
  end

  // One multiplier bit per cycle: add, then shift the pair right
  assign sum = {1'b0, acc_q} + (mlo_q[0] ? {1'b0, a_q} : 65'd0);

  assign prod = long_q ? {acc_q, mlo_q} : {16'd0, acc_q, mlo_q[47:16]};

  always_comb begin
    case (ctl.sh)
      dosc_pkg::SH_32: shifted = prod >> 32;
      dosc_pkg::SH_33: shifted = prod >> 33;
      default:         shifted = prod >> 16;
    endcase
  end

  // A negative result may reach magnitude 2^47, a positive one 2^47 - 1
  assign over_u = |shifted[111:48];
  assign over_s = neg_q ? (over_u || (shifted[47] && (|shifted[46:0])))
                        : (|shifted[111:47]);
  assign r48 = over_s ? (neg_q ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF)
                      : shifted[47:0];

  assign res48 = res_q[47:0];
  assign fsum  = 50'sd0 - ({{2{f_q[47]}}, f_q} + {{2{res48[47]}}, res48});
  assign vsum  = {{2{v_q[47]}}, v_q} + {{2{res48[47]}}, res48};
  assign xsum  = {{2{x_q[47]}}, x_q} + {{2{res48[47]}}, res48};
  assign tot   = {1'b0, ke_q} + {1'b0, pe_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dosc_pkg::ST_IDLE;
      op_q        <= dosc_pkg::OP_FS;
      cnt_q       <= 6'd0;
      out_valid_q <= 1'b0;
      stiff_q     <= dosc_pkg::STIFFNESS_RST;
      damp_q      <= dosc_pkg::DAMPING_RST;
      mass_q      <= dosc_pkg::MASS_RST;
      invm_q      <= dosc_pkg::INVERSE_MASS_RST;
      dt_q        <= dosc_pkg::TIME_STEP_RST;
      x_q         <= 48'sd0;
      v_q         <= dosc_pkg::VEL_RST;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (load_en) begin
        cnt_q <= ctl.long_mul ? dosc_pkg::MUL_LONG : dosc_pkg::MUL_SHORT;
      end else if (run_en) begin
        cnt_q <= cnt_q - 6'd1;
      end
      if (done_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          dosc_pkg::CFG_STIFFNESS:    stiff_q <= cfg_data_i;
          dosc_pkg::CFG_DAMPING:      damp_q  <= cfg_data_i;
          dosc_pkg::CFG_MASS:         mass_q  <= cfg_data_i;
          dosc_pkg::CFG_INVERSE_MASS: invm_q  <= cfg_data_i;
          dosc_pkg::CFG_TIME_STEP:    dt_q    <= cfg_data_i;
          default:                    dt_q    <= dt_q;
        endcase
      end
      if (post_en) begin
        case (op_q)
          dosc_pkg::OP_DV, dosc_pkg::OP_IV: v_q <= dosc_pkg::sat48(vsum);
          dosc_pkg::OP_DX:                  x_q <= dosc_pkg::sat48(xsum);
          default:                          x_q <= x_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= in_data_i.cmd;
      force_q <= in_data_i.force_req;
    end
    if (load_en) begin
      a_q    <= mul_a;
      mlo_q  <= mul_b;
      acc_q  <= 64'd0;
      long_q <= ctl.long_mul;
      neg_q  <= (ctl.cap == dosc_pkg::CAP_S48) && src[47];
    end else if (run_en) begin
      acc_q <= sum[64:1];
      mlo_q <= {sum[0], mlo_q[47:1]};
    end
    if (fin_en) begin
      case (ctl.cap)
        dosc_pkg::CAP_NONE: res_q <= shifted[63:0];
        dosc_pkg::CAP_U48:  res_q <= {16'd0, over_u ? dosc_pkg::U48_MAX : shifted[47:0]};
        default:            res_q <= {16'd0, neg_q ? (48'd0 - r48) : r48};
      endcase
    end
    if (post_en) begin
      case (op_q)
        dosc_pkg::OP_FS, dosc_pkg::OP_A, dosc_pkg::OP_IP: f_q <= res48;
        dosc_pkg::OP_FD:                  f_q  <= dosc_pkg::sat48(fsum);
        dosc_pkg::OP_KE1, dosc_pkg::OP_PE1: t_q <= res_q;
        dosc_pkg::OP_KE2:                 ke_q <= res48;
        dosc_pkg::OP_PE2:                 pe_q <= res48;
        default:                          f_q  <= f_q;
      endcase
    end
    if (done_en) begin
      out_q.position   <= x_q;
      out_q.energy_kin <= ke_q;
      out_q.energy_pot <= pe_q;
      out_q.energy_sum <= tot[48] ? dosc_pkg::U48_MAX : tot[47:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_start_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == dosc_pkg::ST_LOAD) &&
                (op_q == ($past(in_data_i.cmd) ? dosc_pkg::OP_IP : dosc_pkg::OP_FS)))
    else $error("item did not start the right operation");

  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dosc_pkg::ST_RUN) |-> (cnt_q != 6'd0))
    else $error("multiplier running with zero count");

  a_cmd_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dosc_pkg::ST_LOAD && (op_q == dosc_pkg::OP_IP || op_q == dosc_pkg::OP_FS))
    |-> ((op_q == dosc_pkg::OP_IP) == cmd_q))
    else $error("operation sequence does not match the command");

  a_energy_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.energy_sum >= out_data_o.energy_kin) &&
                    (out_data_o.energy_sum >= out_data_o.energy_pot))
    else $error("total energy below one of its parts");
`endif

endmodule
